@@ sv/ptr_pkg.sv @@
// ----------------------------------------------------------------------------
// ptr_pkg
// Shared constants, tables and types of the 2D point rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ptr_pkg;

  // Default configuration of the block.
  localparam int unsigned COORD_WIDTH_DEFAULT = 32;
  localparam int unsigned TRIG_STAGES_DEFAULT = 16;
  localparam int unsigned MAX_TRIG_STAGES     = 24;

  // Angle format: 1/128 degree per unit, one full turn is 46080 units.
  localparam int unsigned ANGLE_WIDTH     = 17;
  localparam int unsigned HALF_TURN_DEG   = 180;
  localparam int unsigned UNITS_PER_DEG   = 128;
  localparam int unsigned FULL_TURN_UNITS = 2 * HALF_TURN_DEG * UNITS_PER_DEG;
  localparam int unsigned ANGLE_OFFSET    = 2 * FULL_TURN_UNITS;

  // Binary angle: a full turn is 2^32. The turn splits into 512 sectors of
  // 90 angle units each, so the sector number gives the top binary-angle bits.
  localparam int unsigned BAM_WIDTH      = 32;
  localparam int unsigned SECTOR_BITS    = 9;
  localparam int unsigned SECTOR_UNITS   = FULL_TURN_UNITS / (2 ** SECTOR_BITS);
  localparam int unsigned FRAC_BAM_WIDTH = BAM_WIDTH - SECTOR_BITS;

  // Offset angle and its division by the sector size through a reciprocal.
  localparam int unsigned WRAP_WIDTH  = $clog2((2 ** (ANGLE_WIDTH - 1)) + ANGLE_OFFSET);
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_MULT  = ((2 ** RECIP_SHIFT) + SECTOR_UNITS - 1) / SECTOR_UNITS;
  localparam int unsigned RECIP_WIDTH = $clog2(RECIP_MULT + 1);
  localparam int unsigned QUOT_WIDTH  = WRAP_WIDTH + RECIP_WIDTH - RECIP_SHIFT;
  localparam int unsigned REM_WIDTH   = $clog2(SECTOR_UNITS);

  // Quadrant codes of the binary angle that get folded by half a turn.
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;

  // CORDIC datapath: Q30 values in a 32-bit word, fixed starting gain.
  localparam int unsigned CORDIC_WIDTH = 32;
  localparam int unsigned CORDIC_FRAC  = 30;
  localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

  // Arctangent of 2^-i in binary-angle units.
  localparam logic signed [BAM_WIDTH-1:0] ATAN_BAM [MAX_TRIG_STAGES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // Fraction bits of the sine and cosine handed to the multipliers.
  function automatic int unsigned trig_frac(int unsigned coord_width);
    return ((62 - coord_width) < CORDIC_FRAC) ? (62 - coord_width) : CORDIC_FRAC;
  endfunction

  // Low binary-angle bits for each remainder within a sector, rounded half up.
  typedef logic [SECTOR_UNITS-1:0][FRAC_BAM_WIDTH-1:0] frac_lut_t;

  function automatic frac_lut_t build_frac_lut();
    frac_lut_t lut;
    longint    num;
    for (int i = 0; i < SECTOR_UNITS; i++) begin
      num    = (longint'(i) << FRAC_BAM_WIDTH) + longint'(SECTOR_UNITS / 2);
      lut[i] = FRAC_BAM_WIDTH'(num / SECTOR_UNITS);
    end
    return lut;
  endfunction

  localparam frac_lut_t FRAC_LUT = build_frac_lut();

  // Angle handed from the reduction stages to the CORDIC pipeline.
  typedef struct packed {
    logic                        valid;
    logic                        flip;
    logic signed [BAM_WIDTH-1:0] z;
  } angle_tag_t;

endpackage

`default_nettype wire

@@ sv/ptr_stream_if.sv @@
// ----------------------------------------------------------------------------
// ptr_stream_if
// Valid/ready channels carrying input points and rotated results.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: angle and the three homogeneous coordinates.
interface ptr_in_if import ptr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) ();
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_w;

  modport source (output valid, angle, point_x, point_y, point_w, input ready);
  modport sink   (input valid, angle, point_x, point_y, point_w, output ready);
endinterface

// Output channel: rotated coordinates, passed-through w and the clamp flag.
interface ptr_out_if import ptr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rotated_x;
  logic signed [COORD_WIDTH-1:0] rotated_y;
  logic signed [COORD_WIDTH-1:0] out_w;
  logic                          saturated;

  modport source (output valid, rotated_x, rotated_y, out_w, saturated, input ready);
  modport sink   (input valid, rotated_x, rotated_y, out_w, saturated, output ready);
endinterface

`default_nettype wire

@@ sv/ptr_angle_reduce.sv @@
// ----------------------------------------------------------------------------
// ptr_angle_reduce
// Three-stage reduction of the angle to a folded binary angle for CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_angle_reduce import ptr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  input  logic [3*COORD_WIDTH-1:0]      pts_i,
  output angle_tag_t                    tag_o,
  output logic [3*COORD_WIDTH-1:0]      pts_o
);

  localparam int unsigned PTS_WIDTH  = 3 * COORD_WIDTH;
  localparam int unsigned PROD_WIDTH = WRAP_WIDTH + RECIP_WIDTH;

  // Stage 1: offset angle and its product with the sector reciprocal.
  logic                    vld1_q;
  logic [WRAP_WIDTH-1:0]   wrap_d, wrap_q;
  logic [PROD_WIDTH-1:0]   prod_d, prod_q;
  logic [PTS_WIDTH-1:0]    pts1_q;

  // Stage 2: sector number and remainder within the sector.
  logic                    vld2_q;
  logic [QUOT_WIDTH-1:0]   quot;
  logic [SECTOR_BITS-1:0]  sect_d, sect_q;
  logic [REM_WIDTH-1:0]    rem_d, rem_q;
  logic [PTS_WIDTH-1:0]    pts2_q;

  // Stage 3: binary angle folded into the right half plane.
  logic                    vld3_q;
  logic [BAM_WIDTH-1:0]    bam;
  logic                    flip_d, flip_q;
  logic [BAM_WIDTH-1:0]    z_d, z_q;
  logic [PTS_WIDTH-1:0]    pts3_q;

  // The offset keeps every 17-bit angle positive; sector count is angle / 90.
  always_comb begin
    wrap_d = WRAP_WIDTH'(int'(angle_i) + int'(ANGLE_OFFSET));
    prod_d = PROD_WIDTH'(wrap_d) * PROD_WIDTH'(RECIP_MULT);
  end

  // Quotient modulo 512 is the sector within one turn; the remainder is exact.
  always_comb begin
    quot   = prod_q[RECIP_SHIFT +: QUOT_WIDTH];
    sect_d = quot[SECTOR_BITS-1:0];
    rem_d  = REM_WIDTH'(wrap_q - (WRAP_WIDTH'(quot) * WRAP_WIDTH'(SECTOR_UNITS)));
  end

  // Second and third quadrant angles are turned by half a turn.
  always_comb begin
    bam    = {sect_q, FRAC_LUT[rem_q]};
    flip_d = (bam[BAM_WIDTH-1:BAM_WIDTH-2] == QUAD_SECOND) ||
             (bam[BAM_WIDTH-1:BAM_WIDTH-2] == QUAD_THIRD);
    z_d    = {bam[BAM_WIDTH-1] ^ flip_d, bam[BAM_WIDTH-2:0]};
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wrap_q <= wrap_d;
      prod_q <= prod_d;
      pts1_q <= pts_i;
      sect_q <= sect_d;
      rem_q  <= rem_d;
      pts2_q <= pts1_q;
      flip_q <= flip_d;
      z_q    <= z_d;
      pts3_q <= pts2_q;
    end
  end

  assign tag_o = '{valid: vld3_q, flip: flip_q, z: signed'(z_q)};
  assign pts_o = pts3_q;

  // The reciprocal division must leave a remainder inside one sector.
  a_rem_in_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld2_q |-> (rem_q < REM_WIDTH'(SECTOR_UNITS)))
    else $error("angle remainder outside the sector");

  // After folding, the angle lies within a quarter turn of zero.
  a_folded_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> (z_q[BAM_WIDTH-1] == z_q[BAM_WIDTH-2]))
    else $error("folded angle outside the right half plane");

endmodule

`default_nettype wire

@@ sv/ptr_cordic.sv @@
// ----------------------------------------------------------------------------
// ptr_cordic
// Rotation-mode CORDIC, one iteration per register stage, plus a final stage
// that undoes the half-turn fold and rounds sine and cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_cordic import ptr_pkg::*; #(
  parameter int unsigned COORD_WIDTH           = COORD_WIDTH_DEFAULT,
  parameter int unsigned TRIG_PRECISION_STAGES = TRIG_STAGES_DEFAULT
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     adv_i,
  input  angle_tag_t                               tag_i,
  input  logic [3*COORD_WIDTH-1:0]                 pts_i,
  output logic                                     valid_o,
  output logic signed [trig_frac(COORD_WIDTH)+1:0] cos_o,
  output logic signed [trig_frac(COORD_WIDTH)+1:0] sin_o,
  output logic [3*COORD_WIDTH-1:0]                 pts_o
);

  localparam int unsigned NUM_STAGES  = (TRIG_PRECISION_STAGES < MAX_TRIG_STAGES) ?
                                        TRIG_PRECISION_STAGES : MAX_TRIG_STAGES;
  localparam int unsigned LAST        = NUM_STAGES - 1;
  localparam int unsigned PTS_WIDTH   = 3 * COORD_WIDTH;
  localparam int unsigned TRIG_FRAC   = trig_frac(COORD_WIDTH);
  localparam int unsigned TRIG_WIDTH  = TRIG_FRAC + 2;
  localparam int unsigned ROUND_SHIFT = CORDIC_FRAC - TRIG_FRAC;
  localparam logic signed [TRIG_WIDTH-1:0] TRIG_LIM =
    TRIG_WIDTH'((64'sd1 <<< TRIG_FRAC) + (64'sd1 <<< (TRIG_FRAC - 3)));

  // Iteration registers and their next values.
  logic                           vld_d  [NUM_STAGES];
  logic                           vld_q  [NUM_STAGES];
  logic                           flip_d [NUM_STAGES];
  logic                           flip_q [NUM_STAGES];
  logic signed [BAM_WIDTH-1:0]    z_d    [NUM_STAGES];
  logic signed [BAM_WIDTH-1:0]    z_q    [NUM_STAGES];
  logic signed [CORDIC_WIDTH-1:0] x_d    [NUM_STAGES];
  logic signed [CORDIC_WIDTH-1:0] x_q    [NUM_STAGES];
  logic signed [CORDIC_WIDTH-1:0] y_d    [NUM_STAGES];
  logic signed [CORDIC_WIDTH-1:0] y_q    [NUM_STAGES];
  logic [PTS_WIDTH-1:0]           pts_d  [NUM_STAGES];
  logic [PTS_WIDTH-1:0]           pts_q  [NUM_STAGES];

  // Output stage.
  logic                           vldf_q;
  logic signed [CORDIC_WIDTH-1:0] cos_full, sin_full;
  logic signed [TRIG_WIDTH-1:0]   cos_d, cos_q, sin_d, sin_q;
  logic [PTS_WIDTH-1:0]           ptsf_q;

  // One micro-rotation per stage; the residual angle's sign picks the direction.
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    logic                           vld_in, flip_in;
    logic signed [BAM_WIDTH-1:0]    z_in;
    logic signed [CORDIC_WIDTH-1:0] x_in, y_in, dx, dy;
    logic [PTS_WIDTH-1:0]           pts_in;

    if (i == 0) begin : g_head
      assign vld_in  = tag_i.valid;
      assign flip_in = tag_i.flip;
      assign z_in    = tag_i.z;
      assign x_in    = CORDIC_GAIN;
      assign y_in    = '0;
      assign pts_in  = pts_i;
    end else begin : g_body
      assign vld_in  = vld_q[i-1];
      assign flip_in = flip_q[i-1];
      assign z_in    = z_q[i-1];
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign pts_in  = pts_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_comb begin
      vld_d[i]  = vld_in;
      flip_d[i] = flip_in;
      pts_d[i]  = pts_in;
      if (!z_in[BAM_WIDTH-1]) begin
        x_d[i] = x_in - dx;
        y_d[i] = y_in + dy;
        z_d[i] = z_in - ATAN_BAM[i];
      end else begin
        x_d[i] = x_in + dx;
        y_d[i] = y_in - dy;
        z_d[i] = z_in + ATAN_BAM[i];
      end
    end
  end

  // Valid bits of the iteration stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (adv_i) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        vld_q[i] <= vld_d[i];
      end
    end
  end

  // Payload of the iteration stages.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        flip_q[i] <= flip_d[i];
        z_q[i]    <= z_d[i];
        x_q[i]    <= x_d[i];
        y_q[i]    <= y_d[i];
        pts_q[i]  <= pts_d[i];
      end
    end
  end

  // Undo the half-turn fold, then round Q30 to the multiplier format.
  assign cos_full = flip_q[LAST] ? -x_q[LAST] : x_q[LAST];
  assign sin_full = flip_q[LAST] ? -y_q[LAST] : y_q[LAST];

  if (ROUND_SHIFT == 0) begin : g_no_round
    assign cos_d = TRIG_WIDTH'(cos_full);
    assign sin_d = TRIG_WIDTH'(sin_full);
  end else begin : g_round
    localparam logic signed [CORDIC_WIDTH:0] ROUND_HALF =
      (CORDIC_WIDTH + 1)'(1) << (ROUND_SHIFT - 1);
    logic signed [CORDIC_WIDTH:0] cos_ext, sin_ext;
    assign cos_ext = (CORDIC_WIDTH + 1)'(cos_full) + ROUND_HALF;
    assign sin_ext = (CORDIC_WIDTH + 1)'(sin_full) + ROUND_HALF;
    assign cos_d   = TRIG_WIDTH'(cos_ext >>> ROUND_SHIFT);
    assign sin_d   = TRIG_WIDTH'(sin_ext >>> ROUND_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldf_q <= 1'b0;
    end else if (adv_i) begin
      vldf_q <= vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cos_q  <= cos_d;
      sin_q  <= sin_d;
      ptsf_q <= pts_q[LAST];
    end
  end

  assign valid_o = vldf_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign pts_o   = ptsf_q;

  // The rotated unit vector keeps its length close to one.
  a_trig_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vldf_q |-> (cos_q <= TRIG_LIM && cos_q >= -TRIG_LIM &&
                sin_q <= TRIG_LIM && sin_q >= -TRIG_LIM))
    else $error("sine or cosine out of range");

endmodule

`default_nettype wire

@@ sv/ptr_rotate_mac.sv @@
// ----------------------------------------------------------------------------
// ptr_rotate_mac
// Products, sums, rounding and saturation of the rotated coordinates.
// The last stage is the output register of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module ptr_rotate_mac import ptr_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     adv_i,
  input  logic                                     valid_i,
  input  logic signed [trig_frac(COORD_WIDTH)+1:0] cos_i,
  input  logic signed [trig_frac(COORD_WIDTH)+1:0] sin_i,
  input  logic [3*COORD_WIDTH-1:0]                 pts_i,
  output logic                                     valid_o,
  output logic signed [COORD_WIDTH-1:0]            rotated_x_o,
  output logic signed [COORD_WIDTH-1:0]            rotated_y_o,
  output logic signed [COORD_WIDTH-1:0]            out_w_o,
  output logic                                     saturated_o
);

  localparam int unsigned TRIG_FRAC  = trig_frac(COORD_WIDTH);
  localparam int unsigned TRIG_WIDTH = TRIG_FRAC + 2;
  localparam int unsigned PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;
  localparam int unsigned SUM_WIDTH  = PROD_WIDTH + 1;
  localparam int unsigned RND_WIDTH  = SUM_WIDTH + 1;
  localparam logic signed [RND_WIDTH-1:0] ROUND_HALF = RND_WIDTH'(1) << (TRIG_FRAC - 1);
  localparam logic signed [RND_WIDTH-1:0] SAT_MAX =
    {{(RND_WIDTH - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [RND_WIDTH-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic [COORD_WIDTH-1:0] OUT_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] OUT_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] sx, sy;

  // Stage 1: the four products.
  logic                          vld1_q;
  logic signed [PROD_WIDTH-1:0]  pxc_q, pys_q, pxs_q, pyc_q;
  logic [COORD_WIDTH-1:0]        w1_q;

  // Stage 2: exact sums.
  logic                          vld2_q;
  logic signed [SUM_WIDTH-1:0]   px_d, px_q, py_d, py_q;
  logic [COORD_WIDTH-1:0]        w2_q;

  // Stage 3: round and clamp.
  logic                          vld3_q;
  logic signed [RND_WIDTH-1:0]   rx, ry;
  logic                          hi_x, lo_x, hi_y, lo_y;
  logic [COORD_WIDTH-1:0]        rx_d, rx_q, ry_d, ry_q, w3_q;
  logic                          sat_d, sat_q;

  assign sx = signed'(pts_i[COORD_WIDTH-1:0]);
  assign sy = signed'(pts_i[2*COORD_WIDTH-1:COORD_WIDTH]);

  always_comb begin
    px_d = SUM_WIDTH'(pxc_q) - SUM_WIDTH'(pys_q);
    py_d = SUM_WIDTH'(pxs_q) + SUM_WIDTH'(pyc_q);
  end

  // Round half up to the coordinate format, then clamp to its range.
  always_comb begin
    rx   = (RND_WIDTH'(px_q) + ROUND_HALF) >>> TRIG_FRAC;
    ry   = (RND_WIDTH'(py_q) + ROUND_HALF) >>> TRIG_FRAC;
    hi_x = rx > SAT_MAX;
    lo_x = rx < SAT_MIN;
    hi_y = ry > SAT_MAX;
    lo_y = ry < SAT_MIN;
    rx_d = hi_x ? OUT_MAX : (lo_x ? OUT_MIN : rx[COORD_WIDTH-1:0]);
    ry_d = hi_y ? OUT_MAX : (lo_y ? OUT_MIN : ry[COORD_WIDTH-1:0]);
    sat_d = hi_x | lo_x | hi_y | lo_y;
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // Payload registers; each multiplier result is registered before the sums.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pxc_q <= PROD_WIDTH'(sx) * PROD_WIDTH'(cos_i);
      pys_q <= PROD_WIDTH'(sy) * PROD_WIDTH'(sin_i);
      pxs_q <= PROD_WIDTH'(sx) * PROD_WIDTH'(sin_i);
      pyc_q <= PROD_WIDTH'(sy) * PROD_WIDTH'(cos_i);
      w1_q  <= pts_i[3*COORD_WIDTH-1:2*COORD_WIDTH];
      px_q  <= px_d;
      py_q  <= py_d;
      w2_q  <= w1_q;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      sat_q <= sat_d;
      w3_q  <= w2_q;
    end
  end

  assign valid_o     = vld3_q;
  assign rotated_x_o = signed'(rx_q);
  assign rotated_y_o = signed'(ry_q);
  assign out_w_o     = signed'(w3_q);
  assign saturated_o = sat_q;

  // A flagged result carries at least one coordinate at a range limit.
  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld3_q && sat_q) |-> (rx_q == OUT_MAX || rx_q == OUT_MIN ||
                           ry_q == OUT_MAX || ry_q == OUT_MIN))
    else $error("saturation flag without a clamped coordinate");

endmodule

`default_nettype wire

@@ sv/point_rotation_2d.sv @@
// ----------------------------------------------------------------------------
// point_rotation_2d
// Counterclockwise rotation of a homogeneous 2D point by an angle in degrees.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one transaction per point: the angle in 1/128 degree and the
//   Q16.16 coordinates x, y and w. out_o returns one transaction per point,
//   in order: x*cos - y*sin and x*sin + y*cos, rounded and saturated, w
//   unchanged, and a flag that is set when either coordinate was clamped.
//   Every angle pattern is accepted and reduced modulo a full turn.
// Pipeline and throughput:
//   A point passes three angle reduction stages, one CORDIC iteration per
//   stage, one rounding stage and three multiply, sum and saturate stages.
//   One point is accepted every cycle while the pipeline is not stalled.
// Reset and stalls:
//   Reset empties the pipeline; no transaction is in flight afterwards.
//   When the receiver holds ready low with a result waiting, the whole
//   pipeline holds and in_i.ready drops; no data is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotation_2d import ptr_pkg::*; #(
  parameter int unsigned COORD_WIDTH           = COORD_WIDTH_DEFAULT,
  parameter int unsigned TRIG_PRECISION_STAGES = TRIG_STAGES_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptr_in_if.sink    in_i,
  ptr_out_if.source out_o
);

  localparam int unsigned PTS_WIDTH  = 3 * COORD_WIDTH;
  localparam int unsigned TRIG_WIDTH = trig_frac(COORD_WIDTH) + 2;

  logic                         adv;
  logic [PTS_WIDTH-1:0]         pts_in, pts_ang, pts_trig;
  angle_tag_t                   tag;
  logic                         trig_valid;
  logic signed [TRIG_WIDTH-1:0] cos_v, sin_v;

  // The pipeline moves whenever the output register is free or being drained.
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;
  assign pts_in     = {in_i.point_w, in_i.point_y, in_i.point_x};

  ptr_angle_reduce #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .angle_i (in_i.angle),
    .pts_i   (pts_in),
    .tag_o   (tag),
    .pts_o   (pts_ang)
  );

  ptr_cordic #(
    .COORD_WIDTH           (COORD_WIDTH),
    .TRIG_PRECISION_STAGES (TRIG_PRECISION_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .tag_i   (tag),
    .pts_i   (pts_ang),
    .valid_o (trig_valid),
    .cos_o   (cos_v),
    .sin_o   (sin_v),
    .pts_o   (pts_trig)
  );

  ptr_rotate_mac #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (trig_valid),
    .cos_i       (cos_v),
    .sin_i       (sin_v),
    .pts_i       (pts_trig),
    .valid_o     (out_o.valid),
    .rotated_x_o (out_o.rotated_x),
    .rotated_y_o (out_o.rotated_y),
    .out_w_o     (out_o.out_w),
    .saturated_o (out_o.saturated)
  );

endmodule

`default_nettype wire

@@ dv/tb_point_rotation_2d.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_rotation_2d
// Self-checking testbench for the 2D homogeneous point rotation pipeline.
// ----------------------------------------------------------------------------
// A scoreboard class predicts every rotated point from its own fixed-point
// CORDIC and compares each output transaction, field by field and in order,
// with the oldest prediction. A directed set covers the angle extremes,
// quadrant edges and clamping in both directions. Random points follow under
// three flow-control mixes on the input and output channels.
// ----------------------------------------------------------------------------

module tb_point_rotation_2d;
  import ptr_pkg::*;

  localparam int COORD_W      = COORD_WIDTH_DEFAULT;
  localparam int TRIG_STAGES  = TRIG_STAGES_DEFAULT;
  localparam int FULL_TURN    = 46080;
  localparam int QUARTER_TURN = FULL_TURN / 4;
  localparam int Q30_BITS     = 30;
  localparam int TRIG_FRAC_BITS = ((62 - COORD_W) < Q30_BITS) ? (62 - COORD_W) : Q30_BITS;
  localparam int STAGE_LIMIT  = 24;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam int PIPE_LATENCY = TRIG_STAGES + 7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTED = 10;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

  // Arctangent of 2^-i as a fraction of a full turn scaled to 2^32.
  localparam longint ATAN_TURN [STAGE_LIMIT] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [ANGLE_WIDTH-1:0] angle;
    logic signed [COORD_W-1:0]     rotated_x;
    logic signed [COORD_W-1:0]     rotated_y;
    logic signed [COORD_W-1:0]     out_w;
    logic                          saturated;
  } rotated_point_t;

  // Predicts rotated points and checks the output stream against them.
  class rotation_scoreboard;
    rotated_point_t pending_rotations[$];
    int unsigned    points_noted;
    int unsigned    results_checked;
    int unsigned    clamped_results;
    int unsigned    wide_angles;
    int unsigned    mismatch_count;

    // Divide by 2^s, rounding halves up; s of zero leaves the value alone.
    function longint round_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Cosine and sine of the angle through a rotation-mode CORDIC.
    function void unit_vector(input logic signed [ANGLE_WIDTH-1:0] angle,
                              output longint cos_q, output longint sin_q);
      longint      turn_pos;
      longint      bam_full;
      logic [31:0] bam;
      logic        flip;
      longint      z;
      longint      cx;
      longint      cy;
      longint      dx;
      longint      dy;
      turn_pos = (longint'(angle) + 2 * FULL_TURN) % FULL_TURN;
      bam_full = ((turn_pos <<< 32) + FULL_TURN / 2) / FULL_TURN;
      bam      = bam_full[31:0];
      // Fold the second and third quadrant by half a turn.
      flip = (bam[31:30] == QUAD_SECOND) || (bam[31:30] == QUAD_THIRD);
      if (flip) bam[31] = ~bam[31];
      z  = longint'($signed(bam));
      cx = GAIN_Q30;
      cy = 0;
      for (int i = 0; i < TRIG_STAGES && i < STAGE_LIMIT; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx;
          cy += dy;
          z  -= ATAN_TURN[i];
        end else begin
          cx += dx;
          cy -= dy;
          z  += ATAN_TURN[i];
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      cos_q = round_shift(cx, Q30_BITS - TRIG_FRAC_BITS);
      sin_q = round_shift(cy, Q30_BITS - TRIG_FRAC_BITS);
    endfunction

    // Clamp a rounded coordinate to the signed output range.
    function longint clamp_coord(longint v, inout logic clamped);
      longint lim_hi;
      longint lim_lo;
      lim_hi = (64'sd1 <<< (COORD_W - 1)) - 1;
      lim_lo = -lim_hi - 1;
      if (v > lim_hi) begin
        clamped = 1'b1;
        return lim_hi;
      end
      if (v < lim_lo) begin
        clamped = 1'b1;
        return lim_lo;
      end
      return v;
    endfunction

    function rotated_point_t rotate_point(logic signed [ANGLE_WIDTH-1:0] angle,
                                          logic signed [COORD_W-1:0] x,
                                          logic signed [COORD_W-1:0] y,
                                          logic signed [COORD_W-1:0] w);
      rotated_point_t res;
      longint         cos_q;
      longint         sin_q;
      longint         sum_x;
      longint         sum_y;
      logic           clamped;
      unit_vector(angle, cos_q, sin_q);
      clamped = 1'b0;
      sum_x = round_shift(longint'(x) * cos_q - longint'(y) * sin_q, TRIG_FRAC_BITS);
      sum_y = round_shift(longint'(x) * sin_q + longint'(y) * cos_q, TRIG_FRAC_BITS);
      sum_x = clamp_coord(sum_x, clamped);
      sum_y = clamp_coord(sum_y, clamped);
      res.angle     = angle;
      res.rotated_x = sum_x[COORD_W-1:0];
      res.rotated_y = sum_y[COORD_W-1:0];
      res.out_w     = w;
      res.saturated = clamped;
      return res;
    endfunction

    function void note_point(logic signed [ANGLE_WIDTH-1:0] angle,
                             logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] w);
      points_noted++;
      if (angle > FULL_TURN || angle < -FULL_TURN) wide_angles++;
      pending_rotations.push_back(rotate_point(angle, x, y, w));
    endfunction

    function void check_result(logic signed [COORD_W-1:0] rx,
                               logic signed [COORD_W-1:0] ry,
                               logic signed [COORD_W-1:0] w,
                               logic                      sat);
      rotated_point_t want;
      if (pending_rotations.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("ERROR: result x %0d y %0d arrived with no point pending", rx, ry);
        return;
      end
      want = pending_rotations.pop_front();
      results_checked++;
      if (want.saturated) clamped_results++;
      if (rx !== want.rotated_x || ry !== want.rotated_y || w !== want.out_w ||
          sat !== want.saturated) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("ERROR: angle %0d: expected x %0d y %0d w %0d sat %0b, got x %0d y %0d w %0d sat %0b",
                   want.angle, want.rotated_x, want.rotated_y, want.out_w, want.saturated,
                   rx, ry, w, sat);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   cycle_count;

  rotation_scoreboard sb;

  ptr_in_if  #(.COORD_WIDTH(COORD_W)) in_if ();
  ptr_out_if #(.COORD_WIDTH(COORD_W)) out_if ();

  point_rotation_2d #(
    .COORD_WIDTH          (COORD_W),
    .TRIG_PRECISION_STAGES(TRIG_STAGES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock with a 4 ns period.
  always #2 clk_i = ~clk_i;

  // The receiver stalls at random at the rate of the current phase.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Every transaction on either channel goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_point(in_if.angle, in_if.point_x, in_if.point_y, in_if.point_w);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.rotated_x, out_if.rotated_y, out_if.out_w, out_if.saturated);
    end
  end

  // Hard limit on the run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Offer one point, possibly after random idle cycles, and hold it until
  // taken. Called and returns at a falling edge; valid stays high afterwards.
  task automatic send_point(input int angle_units, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] w);
    logic taken;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.angle   = ANGLE_WIDTH'(angle_units);
    in_if.point_x = x;
    in_if.point_y = y;
    in_if.point_w = w;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = in_if.ready;
      @(negedge clk_i);
    end
  endtask

  // Coordinates mixing the full range, moderate and small values, and values
  // next to the extremes.
  function automatic logic [COORD_W-1:0] random_coord();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(3))
      0:       return COORD_W'(raw);
      1:       return {{(COORD_W - 24){raw[23]}}, raw[23:0]};
      2:       return raw[31] ? COORD_MAX - raw[7:0] : COORD_MIN + raw[7:0];
      default: return {{(COORD_W - 18){raw[17]}}, raw[17:0]};
    endcase
  endfunction

  task automatic send_random_points(input int count);
    int angle_units;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        // Any 17-bit pattern, including those beyond a full turn.
        0:       angle_units = int'($urandom_range(131071)) - 65536;
        // Close to a quadrant boundary.
        1, 2:    angle_units = QUARTER_TURN * int'($urandom_range(8)) - FULL_TURN +
                               int'($urandom_range(8)) - 4;
        default: angle_units = int'($urandom_range(2 * FULL_TURN)) - FULL_TURN;
      endcase
      send_point(angle_units, random_coord(), random_coord(), COORD_W'($urandom));
    end
  endtask

  // Angle extremes, quadrant edges, pass-through of w and clamping both ways.
  task automatic send_directed_points();
    send_point(0, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_point(QUARTER_TURN, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_point(2 * QUARTER_TURN, COORD_MIN, 0, COORD_MAX);
    send_point(3 * QUARTER_TURN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(FULL_TURN, COORD_MAX, COORD_MAX, 0);
    send_point(-FULL_TURN, COORD_MIN, COORD_MAX, '1);
    send_point(-65536, 32'h0030_3900, 32'hFFE5_7B00, 5);
    send_point(65535, COORD_MAX, COORD_MIN, 1);
    send_point(-1, 32'h0001_0000, 32'h0001_0000, 0);
    send_point(1, 32'h0001_0000, 32'hFFFF_0000, 0);
    send_point(QUARTER_TURN / 2, COORD_MAX, COORD_MAX, 32'h8000_0001);
    send_point(QUARTER_TURN / 2, COORD_MIN, COORD_MIN, 32'h7FFF_FFFE);
    send_point(3 * QUARTER_TURN / 2, COORD_MAX, COORD_MAX, 0);
    send_point(-3 * QUARTER_TURN / 2, COORD_MIN, COORD_MAX, 0);
    send_point(QUARTER_TURN - 1, COORD_MIN, COORD_MIN, 0);
    send_point(QUARTER_TURN + 1, COORD_MAX, COORD_MIN, 0);
    send_point(2 * QUARTER_TURN - 1, 32'h1234_5678, 32'h8765_4321, 0);
    send_point(2 * QUARTER_TURN + 1, COORD_MIN, 1, 0);
    send_point(3 * QUARTER_TURN - 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
    send_point(3 * QUARTER_TURN + 1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_point(45, 32'h0001_0000, 32'h0001_0000, 32'h5555_5555);
    send_point(0, 0, 0, 0);
    send_point(-2 * QUARTER_TURN, COORD_MAX, COORD_MIN, COORD_MIN);
  endtask

  // Main sequence: reset, directed points, three random phases, drain.
  initial begin
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    src_idle_pct  = 32;
    sink_idle_pct = 65;
    in_if.valid   = 1'b0;
    in_if.angle   = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_w = '0;
    out_if.ready  = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    send_directed_points();
    send_random_points(480);
    src_idle_pct  = 65;
    sink_idle_pct = 32;
    send_random_points(480);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_random_points(490);
    in_if.valid = 1'b0;

    while (sb.pending_rotations.size() != 0) @(posedge clk_i);
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);

    $display("Rotated %0d points, %0d of them clamped, %0d angles beyond a full turn,",
             sb.results_checked, sb.clamped_results, sb.wide_angles);
    $display("over a directed set and three random flow-control mixes; %0d mismatches.",
             sb.mismatch_count);
    if (sb.pending_rotations.size() != 0)
      $display("ERROR: %0d predicted points never came out", sb.pending_rotations.size());
    if (sb.mismatch_count == 0 && sb.pending_rotations.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
